// ----- rtl/mpq_pkg.sv -----
// mpq_pkg: shared constants, types and codes of the max priority queue
// no dependencies

package mpq_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int KW       = 32;

  typedef struct packed {
    logic signed [KW-1:0] key;
    logic signed [KW-1:0] data;
  } entry_t;

  typedef enum logic [2:0] {
    K_INSERT   = 3'd0,
    K_EXTRACT  = 3'd1,
    K_INCREASE = 3'd2,
    K_DELETE   = 3'd3,
    K_PEEK     = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_EMPTY   = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_RANGE   = 3'd3,
    STAT_SMALLER = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_SLOT,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/max_priority_queue.sv -----
// Binary max-heap of key/data entries held in one 64-entry memory with two
// read ports and one write port. One request is worked at a time, and in_ready
// is high only while the block is idle. After acceptance a request fetches the root
// or its slot in ST_ROOT or ST_SLOT where it needs to, then takes a read state and
// a compare-and-write-back state for each heap level that sift-up or sift-down
// walks, up to 6 levels. The result is held in ST_OUT until taken, and the block
// returns to idle before it accepts the next request.
// Signed keys; ties keep the left child and never move.
// depends on mpq_pkg and mpq_mem

module max_priority_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_kind,
  input  logic signed [31:0]   in_new_key,
  input  logic signed [31:0]   in_new_data,
  input  logic [5:0]           in_slot_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic signed [31:0]   out_key,
  output logic signed [31:0]   out_data,
  output logic [6:0]           out_entry_count_out
);
  import mpq_pkg::*;

  state_t          state_r, state_nxt;
  logic [2:0]      kind_r, kind_nxt;
  logic [KW-1:0]   key_r, key_nxt;
  logic [AW-1:0]   slot_r, slot_nxt;
  entry_t          mov_r, mov_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic            moved_r, moved_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [2:0]      status_r, status_nxt;
  entry_t          res_r, res_nxt;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_ent;
  logic [AW-1:0]   rd_a, rd_b;
  entry_t          rda, rdb;

  logic            in_acc;
  logic            full, empty, range_bad;
  logic [AW-1:0]   parent_idx;
  logic [CW-1:0]   left_idx, right_idx;
  logic            right_ok, child_right, dn_gt, up_gt, down_after;
  entry_t          child;
  logic [AW-1:0]   child_idx;

  mpq_mem u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_ent    (wr_ent),
    .rd_addr_a (rd_a),
    .rd_addr_b (rd_b),
    .rd_ent_a  (rda),
    .rd_ent_b  (rdb)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign range_bad = ({1'b0, in_slot_index} >= count_r);

  assign parent_idx  = AW'((pos_r - AW'(1)) >> 1);
  assign left_idx    = {pos_r, 1'b1};
  assign right_idx   = left_idx + CW'(1);
  assign right_ok    = (right_idx < count_r);
  assign child_right = right_ok && (rdb.key > rda.key);
  assign child       = child_right ? rdb : rda;
  assign child_idx   = child_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
  assign dn_gt       = (child.key > mov_r.key);
  assign up_gt       = (mov_r.key > rda.key);
  // a delete whose moved entry did not rise goes on to sift down
  assign down_after  = (kind_r == K_DELETE) && !moved_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_kind) inside
            K_INSERT:              state_nxt = full ? ST_OUT : ST_UP_RD;
            K_EXTRACT, K_PEEK:     state_nxt = empty ? ST_OUT : ST_ROOT;
            K_INCREASE, K_DELETE:  state_nxt = range_bad ? ST_OUT : ST_SLOT;
            default:               state_nxt = ST_OUT;
          endcase
        end
      end
      ST_ROOT: begin
        state_nxt = (kind_r == K_PEEK || count_r == CW'(1)) ? ST_OUT : ST_DN_RD;
      end
      ST_SLOT: begin
        if (kind_r == K_INCREASE) begin
          state_nxt = (rda.key > $signed(key_r)) ? ST_OUT : ST_UP_RD;
        end else begin
          state_nxt = ({1'b0, slot_r} < count_r - CW'(1)) ? ST_UP_RD : ST_OUT;
        end
      end
      ST_UP_RD: begin
        if (pos_r != '0) begin
          state_nxt = ST_UP_CMP;
        end else begin
          state_nxt = down_after ? ST_DN_RD : ST_OUT;
        end
      end
      ST_UP_CMP: begin
        if (up_gt) begin
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = down_after ? ST_DN_RD : ST_OUT;
        end
      end
      ST_DN_RD:  state_nxt = (left_idx >= count_r) ? ST_OUT : ST_DN_CMP;
      ST_DN_CMP: state_nxt = dn_gt ? ST_DN_RD : ST_OUT;
      ST_OUT:    state_nxt = out_ready ? ST_IDLE : ST_OUT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    kind_nxt   = kind_r;
    key_nxt    = key_r;
    slot_nxt   = slot_r;
    mov_nxt    = mov_r;
    pos_nxt    = pos_r;
    moved_nxt  = moved_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    res_nxt    = res_r;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_ent     = mov_r;
    rd_a       = parent_idx;
    rd_b       = AW'(count_r - CW'(1));
    unique case (state_r)
      ST_IDLE: begin
        rd_a = (in_kind == K_EXTRACT || in_kind == K_PEEK) ? '0 : in_slot_index;
        if (in_acc) begin
          kind_nxt     = in_kind;
          key_nxt      = in_new_key;
          slot_nxt     = in_slot_index;
          mov_nxt.key  = in_new_key;
          mov_nxt.data = in_new_data;
          pos_nxt      = AW'(count_r);
          moved_nxt    = 1'b0;
          status_nxt   = STAT_OK;
          res_nxt      = '0;
          case (in_kind) inside
            K_INSERT: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            K_EXTRACT, K_PEEK: begin
              if (empty) begin
                status_nxt = STAT_EMPTY;
              end
            end
            K_INCREASE, K_DELETE: begin
              if (range_bad) begin
                status_nxt = STAT_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROOT: begin
        res_nxt = rda;
        if (kind_r == K_EXTRACT) begin
          count_nxt = count_r - CW'(1);
          mov_nxt   = rdb;
          pos_nxt   = '0;
        end
      end
      ST_SLOT: begin
        pos_nxt = slot_r;
        if (kind_r == K_INCREASE) begin
          if (rda.key > $signed(key_r)) begin
            status_nxt = STAT_SMALLER;
          end else begin
            mov_nxt.key  = key_r;
            mov_nxt.data = rda.data;
          end
        end else begin
          res_nxt   = rda;
          count_nxt = count_r - CW'(1);
          mov_nxt   = rdb;
        end
      end
      ST_UP_RD: begin
        if (pos_r == '0 && !down_after) begin
          wr_en = 1'b1;
        end
      end
      ST_UP_CMP: begin
        if (up_gt) begin
          wr_en     = 1'b1;
          wr_ent    = rda;
          pos_nxt   = parent_idx;
          moved_nxt = 1'b1;
        end else if (!down_after) begin
          wr_en = 1'b1;
        end
      end
      ST_DN_RD: begin
        rd_a = left_idx[AW-1:0];
        rd_b = right_idx[AW-1:0];
        if (left_idx >= count_r) begin
          wr_en = 1'b1;
        end
      end
      ST_DN_CMP: begin
        wr_en = 1'b1;
        if (dn_gt) begin
          wr_ent  = child;
          pos_nxt = child_idx;
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      moved_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      moved_r <= moved_nxt;
    end
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    slot_r   <= slot_nxt;
    mov_r    <= mov_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  assign out_valid           = (state_r == ST_OUT);
  assign out_status          = status_r;
  assign out_key             = res_r.key;
  assign out_data            = res_r.data;
  assign out_entry_count_out = count_r;

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_wr_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ({1'b0, wr_addr} < count_r))
    else $error("write outside the live heap");

  a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_OUT) |-> !wr_en)
    else $error("memory write while no item is in work");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> $stable(count_r))
    else $error("entry count changed after the result was formed");
`endif

endmodule

// ----- rtl/mpq_mem.sv -----
// mpq_mem: heap entry storage, one write port and two registered read ports
// depends on mpq_pkg

module mpq_mem (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [mpq_pkg::AW-1:0] wr_addr,
  input  mpq_pkg::entry_t      wr_ent,
  input  logic [mpq_pkg::AW-1:0] rd_addr_a,
  input  logic [mpq_pkg::AW-1:0] rd_addr_b,
  output mpq_pkg::entry_t      rd_ent_a,
  output mpq_pkg::entry_t      rd_ent_b
);
  import mpq_pkg::*;

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
    rd_ent_a <= mem[rd_addr_a];
    rd_ent_b <= mem[rd_addr_b];
  end

endmodule
